// ===== hdl/assert_macros.svh =====
// assertion macros used by the responder rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in a cycle implies consequence in the same cycle
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition in a cycle implies consequence in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/ucr_pkg.sv =====
// types, constants and the reply rom of the printer control responder
// depends on nothing
`default_nettype none
package ucr_pkg;

  localparam int CONTROL_PACKET_BYTES = 64;
  localparam int BULK_PACKET_BYTES    = 512;

  // configuration store layout (register index equals store entry)
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_ENTRIES   = 6;
  // entries reachable from the register port; the last entry holds the flag
  localparam int CFG_REGISTERS = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_VENDOR_ID   = 3'd0,
    CFG_PRODUCT_ID  = 3'd1,
    CFG_BULK_OUT_EP = 3'd2,
    CFG_BULK_IN_EP  = 3'd3,
    CFG_MAX_POWER   = 3'd4,
    CFG_CONFIGURED  = 3'd5
  } cfg_addr_t;

  // engine to store request
  typedef struct packed {
    logic      rd_en;
    cfg_addr_t rd_addr;
    logic      set_configured;
  } cfg_req_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_STALL = 2'd2
  } reply_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } seq_state_t;

  // request decoding codes
  localparam logic [1:0] RTYPE_STANDARD = 2'd0;
  localparam logic [1:0] RTYPE_CLASS    = 2'd1;

  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;
  localparam logic [7:0] REQ_GET_DEVICE_ID     = 8'd0;
  localparam logic [7:0] REQ_GET_PORT_STATUS   = 8'd1;
  localparam logic [7:0] REQ_SOFT_RESET        = 8'd2;

  localparam logic [7:0] DESC_DEVICE    = 8'd1;
  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_STRING    = 8'd3;
  localparam logic [7:0] DESC_QUALIFIER = 8'd6;

  // reply rom layout
  localparam int ROM_DEPTH = 113;
  localparam int ROM_IDX_W = 7;
  localparam int LEN_W     = 6;

  localparam logic [ROM_IDX_W-1:0] ROM_DEVICE     = 7'd0;
  localparam logic [ROM_IDX_W-1:0] ROM_QUALIFIER  = 7'd18;
  localparam logic [ROM_IDX_W-1:0] ROM_CONFIG     = 7'd28;
  localparam logic [ROM_IDX_W-1:0] ROM_STR0       = 7'd60;
  localparam logic [ROM_IDX_W-1:0] ROM_STRX       = 7'd64;
  localparam logic [ROM_IDX_W-1:0] ROM_DEVICE_ID  = 7'd68;
  localparam logic [ROM_IDX_W-1:0] ROM_ZERO       = 7'd111;
  localparam logic [ROM_IDX_W-1:0] ROM_CONFIG_VAL = 7'd112;
  localparam logic [ROM_IDX_W-1:0] ROM_LAST       = 7'(ROM_DEPTH - 1);

  localparam logic [LEN_W-1:0] LEN_DEVICE    = 6'd18;
  localparam logic [LEN_W-1:0] LEN_QUALIFIER = 6'd10;
  localparam logic [LEN_W-1:0] LEN_CONFIG    = 6'd32;
  localparam logic [LEN_W-1:0] LEN_STRING    = 6'd4;
  localparam logic [LEN_W-1:0] LEN_DEVICE_ID = 6'd43;
  localparam logic [LEN_W-1:0] LEN_ONE       = 6'd1;

  // rom positions replaced by store contents
  localparam logic [ROM_IDX_W-1:0] POS_VID_LO  = ROM_DEVICE + 7'd8;
  localparam logic [ROM_IDX_W-1:0] POS_VID_HI  = ROM_DEVICE + 7'd9;
  localparam logic [ROM_IDX_W-1:0] POS_PID_LO  = ROM_DEVICE + 7'd10;
  localparam logic [ROM_IDX_W-1:0] POS_PID_HI  = ROM_DEVICE + 7'd11;
  localparam logic [ROM_IDX_W-1:0] POS_POWER   = ROM_CONFIG + 7'd8;
  localparam logic [ROM_IDX_W-1:0] POS_OUT_EP  = ROM_CONFIG + 7'd20;
  localparam logic [ROM_IDX_W-1:0] POS_IN_EP   = ROM_CONFIG + 7'd27;

  typedef enum logic [3:0] {
    SRC_CONST, SRC_VID_LO, SRC_VID_HI, SRC_PID_LO, SRC_PID_HI,
    SRC_OUT_EP, SRC_IN_EP, SRC_POWER, SRC_CONFIGURED
  } byte_src_t;

  localparam logic [7:0] CPB    = 8'(CONTROL_PACKET_BYTES);
  localparam logic [7:0] BPB_LO = 8'(BULK_PACKET_BYTES & 255);
  localparam logic [7:0] BPB_HI = 8'((BULK_PACKET_BYTES >> 8) & 255);

  localparam logic [7:0] REPLY_ROM [ROM_DEPTH] = '{
    // device descriptor
    8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, CPB, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h01,
    // device qualifier
    8'd10, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, CPB, 8'h01, 8'h00,
    // configuration, interface and two bulk endpoints
    8'd9, 8'h02, 8'd32, 8'h00, 8'h01, 8'h01, 8'h03, 8'hc0, 8'h00,
    8'd9, 8'h04, 8'h00, 8'h00, 8'h02, 8'h07, 8'h01, 8'h02, 8'h04,
    8'd7, 8'h05, 8'h00, 8'h02, BPB_LO, BPB_HI, 8'h00,
    8'd7, 8'h05, 8'h80, 8'h02, BPB_LO, BPB_HI, 8'h00,
    // language string and one-character string
    8'd4, 8'h03, 8'h09, 8'h04,
    8'd4, 8'h03, 8'h78, 8'h00,
    // device id: big-endian length then text
    8'h00, 8'd43,
    8'h4d, 8'h46, 8'h47, 8'h3a, 8'h6c, 8'h69, 8'h6e, 8'h75, 8'h78, 8'h3b,
    8'h4d, 8'h44, 8'h4c, 8'h3a, 8'h67, 8'h5f, 8'h70, 8'h72, 8'h69, 8'h6e,
    8'h74, 8'h65, 8'h72, 8'h3b, 8'h43, 8'h4c, 8'h53, 8'h3a, 8'h50, 8'h52,
    8'h49, 8'h4e, 8'h54, 8'h45, 8'h52, 8'h3b, 8'h53, 8'h4e, 8'h3a, 8'h31,
    8'h3b,
    // interface setting zero, configuration value
    8'h00, 8'h00
  };

  function automatic byte_src_t byte_src(input logic [ROM_IDX_W-1:0] idx);
    byte_src_t s;
    case (idx)
      POS_VID_LO:     s = SRC_VID_LO;
      POS_VID_HI:     s = SRC_VID_HI;
      POS_PID_LO:     s = SRC_PID_LO;
      POS_PID_HI:     s = SRC_PID_HI;
      POS_POWER:      s = SRC_POWER;
      POS_OUT_EP:     s = SRC_OUT_EP;
      POS_IN_EP:      s = SRC_IN_EP;
      ROM_CONFIG_VAL: s = SRC_CONFIGURED;
      default:        s = SRC_CONST;
    endcase
    return s;
  endfunction

  function automatic cfg_addr_t src_addr(input byte_src_t s);
    cfg_addr_t a;
    case (s)
      SRC_VID_LO, SRC_VID_HI: a = CFG_VENDOR_ID;
      SRC_PID_LO, SRC_PID_HI: a = CFG_PRODUCT_ID;
      SRC_OUT_EP:             a = CFG_BULK_OUT_EP;
      SRC_IN_EP:              a = CFG_BULK_IN_EP;
      SRC_POWER:              a = CFG_MAX_POWER;
      default:                a = CFG_CONFIGURED;
    endcase
    return a;
  endfunction

  // reset contents of the store entries
  function automatic logic [CFG_DATA_W-1:0] cfg_reset_value(input cfg_addr_t a);
    logic [CFG_DATA_W-1:0] v;
    case (a)
      CFG_VENDOR_ID:   v = 16'h0525;
      CFG_PRODUCT_ID:  v = 16'ha4a8;
      CFG_BULK_OUT_EP: v = 16'h0001;
      CFG_BULK_IN_EP:  v = 16'h0002;
      CFG_MAX_POWER:   v = 16'h0032;
      default:         v = 16'h0000;
    endcase
    return v;
  endfunction

  // trim a register write to the register's width
  function automatic logic [CFG_DATA_W-1:0] cfg_mask(input cfg_addr_t a,
                                                      input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] m;
    case (a)
      CFG_BULK_OUT_EP, CFG_BULK_IN_EP: m = {12'h000, v[3:0]};
      CFG_MAX_POWER:                   m = {8'h00, v[7:0]};
      default:                         m = v;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ucr_if.sv =====
// setup packet and reply channel interfaces
// depends on ucr_pkg
`default_nettype none
interface ucr_req_if import ucr_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] request_value;
  logic [15:0] request_index;
  logic [15:0] request_length;

  modport source (output valid, request_type, request_code, request_value,
                  request_index, request_length, input ready);
  modport sink   (input valid, request_type, request_code, request_value,
                  request_index, request_length, output ready);
endinterface

interface ucr_rsp_if import ucr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] reply_kind;
  logic [7:0] data_byte;
  logic       last_item;

  modport source (output valid, reply_kind, data_byte, last_item, input ready);
  modport sink   (input valid, reply_kind, data_byte, last_item, output ready);
endinterface
`default_nettype wire

// ===== hdl/ucr_ram.sv =====
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none
module ucr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ucr_cfg_store.sv =====
// configuration and configured-flag store: ram plus per-entry valid bits
// depends on ucr_pkg and ucr_ram
`default_nettype none
module ucr_cfg_store import ucr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire cfg_req_t               req,
  output logic      [CFG_DATA_W-1:0]  rd_data
);

  logic [CFG_ENTRIES-1:0]  valid_r, valid_nxt;
  logic                    hit_valid_r;
  cfg_addr_t               hit_addr_r;
  logic                    wr_en;
  cfg_addr_t               wr_addr;
  logic [CFG_DATA_W-1:0]   wr_data;
  logic [CFG_DATA_W-1:0]   ram_q;

  // write select: register port, else the configured flag from the engine
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = CFG_CONFIGURED;
    wr_data = '0;
    if (cfg_we && (int'(cfg_index) < CFG_REGISTERS)) begin
      wr_en   = 1'b1;
      wr_addr = cfg_addr_t'(cfg_index);
      wr_data = cfg_mask(cfg_addr_t'(cfg_index), cfg_wdata);
    end else if (req.set_configured) begin
      wr_en   = 1'b1;
      wr_addr = CFG_CONFIGURED;
      wr_data = 16'h0001;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // valid bit and address follow the ram read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      hit_valid_r <= valid_r[req.rd_addr];
      hit_addr_r  <= req.rd_addr;
    end
  end

  ucr_ram #(.WIDTH(CFG_DATA_W), .DEPTH(CFG_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (ram_q)
  );

  // never-written entries read as their reset value
  assign rd_data = hit_valid_r ? ram_q : cfg_reset_value(hit_addr_r);

endmodule
`default_nettype wire

// ===== hdl/ucr_reply_seq.sv =====
// request decode and reply sequencer with output register
// depends on ucr_pkg, ucr_if and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module ucr_reply_seq import ucr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ucr_req_if.sink                    in_chan,
  ucr_rsp_if.source                  out_chan,
  output cfg_req_t                   store_req,
  input  wire logic [CFG_DATA_W-1:0] store_rdata
);

  seq_state_t             state_r, state_nxt;
  logic [ROM_IDX_W-1:0]   idx_r, idx_nxt;
  logic [LEN_W-1:0]       k_r, k_nxt;
  logic [LEN_W-1:0]       n_r, n_nxt;
  reply_kind_t            kind_r, kind_nxt;
  logic                   out_valid_r, out_valid_nxt;
  reply_kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [ROM_IDX_W-1:0]   dec_idx;
  logic [LEN_W-1:0]       dec_len, dec_n;
  reply_kind_t            dec_kind;
  logic                   dec_setcfg;
  logic                   out_free, load, is_last;
  logic [7:0]             emit_byte;
  byte_src_t              cur_src;

  // setup packet decode
  always_comb begin
    dec_idx    = ROM_ZERO;
    dec_len    = '0;
    dec_kind   = KIND_STALL;
    dec_setcfg = 1'b0;
    case (in_chan.request_type[6:5])
      RTYPE_STANDARD: begin
        case (in_chan.request_code)
          REQ_GET_DESCRIPTOR: begin
            case (in_chan.request_value[15:8])
              DESC_DEVICE: begin
                dec_idx = ROM_DEVICE; dec_len = LEN_DEVICE; dec_kind = KIND_DATA;
              end
              DESC_QUALIFIER: begin
                dec_idx = ROM_QUALIFIER; dec_len = LEN_QUALIFIER; dec_kind = KIND_DATA;
              end
              DESC_CONFIG: begin
                dec_idx = ROM_CONFIG; dec_len = LEN_CONFIG; dec_kind = KIND_DATA;
              end
              DESC_STRING: begin
                dec_idx  = (in_chan.request_value[7:0] == 8'h00) ? ROM_STR0 : ROM_STRX;
                dec_len  = LEN_STRING;
                dec_kind = KIND_DATA;
              end
              default: dec_kind = KIND_STALL;
            endcase
          end
          REQ_GET_CONFIGURATION: begin
            dec_idx = ROM_CONFIG_VAL; dec_len = LEN_ONE; dec_kind = KIND_DATA;
          end
          REQ_SET_CONFIGURATION: begin
            dec_kind = KIND_ACK; dec_setcfg = 1'b1;
          end
          REQ_SET_INTERFACE: dec_kind = KIND_ACK;
          REQ_GET_INTERFACE: begin
            dec_idx = ROM_ZERO; dec_len = LEN_ONE; dec_kind = KIND_DATA;
          end
          default: dec_kind = KIND_STALL;
        endcase
      end
      RTYPE_CLASS: begin
        case (in_chan.request_code)
          REQ_GET_DEVICE_ID: begin
            dec_idx = ROM_DEVICE_ID; dec_len = LEN_DEVICE_ID; dec_kind = KIND_DATA;
          end
          REQ_GET_PORT_STATUS, REQ_SOFT_RESET: dec_kind = KIND_ACK;
          default: dec_kind = KIND_STALL;
        endcase
      end
      default: dec_kind = KIND_STALL;
    endcase
    // cut to wLength; nothing left becomes an acknowledge
    dec_n = (in_chan.request_length < {10'h000, dec_len})
            ? in_chan.request_length[LEN_W-1:0] : dec_len;
    if ((dec_kind == KIND_DATA) && (dec_n == '0)) begin
      dec_kind = KIND_ACK;
    end
  end

  // byte composition from rom and store
  always_comb begin
    cur_src = byte_src(idx_r);
    case (cur_src)
      SRC_VID_LO, SRC_PID_LO, SRC_POWER: emit_byte = store_rdata[7:0];
      SRC_VID_HI, SRC_PID_HI:            emit_byte = store_rdata[15:8];
      SRC_OUT_EP:                        emit_byte = {4'h0, store_rdata[3:0]};
      SRC_IN_EP:                         emit_byte = {4'h8, store_rdata[3:0]};
      SRC_CONFIGURED:                    emit_byte = {7'h00, store_rdata[0]};
      default:                           emit_byte = REPLY_ROM[idx_r];
    endcase
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign is_last  = (kind_r != KIND_DATA) || (k_r == (n_r - 6'd1));
  assign in_chan.ready = (state_r == ST_IDLE);

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    kind_nxt  = kind_r;
    load      = 1'b0;
    store_req = '{rd_en: 1'b0, rd_addr: src_addr(cur_src), set_configured: 1'b0};
    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          idx_nxt   = dec_idx;
          k_nxt     = '0;
          n_nxt     = dec_n;
          kind_nxt  = dec_kind;
          store_req.set_configured = dec_setcfg;
          state_nxt = (dec_kind == KIND_DATA) ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        store_req.rd_en = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 7'd1;
            k_nxt     = k_r + 6'd1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = kind_r;
      out_byte_nxt  = (kind_r == KIND_DATA) ? emit_byte : 8'h00;
      out_last_nxt  = is_last;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    kind_r     <= kind_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.reply_kind = out_kind_r;
  assign out_chan.data_byte  = out_byte_r;
  assign out_chan.last_item  = out_last_r;

  // checks
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_chan.valid && in_chan.ready, !in_chan.ready)
  `ASSERT_SAME(a_count_in_range, clk, rst_n, (state_r != ST_IDLE) && (kind_r == KIND_DATA), k_r < n_r)
  `ASSERT_SAME(a_rom_in_range, clk, rst_n, state_r == ST_READ, idx_r <= ROM_LAST)
  `ASSERT_SAME(a_status_is_last, clk, rst_n, out_valid_r && (out_kind_r != KIND_DATA), out_last_r && (out_byte_r == 8'h00))

endmodule
`default_nettype wire

// ===== hdl/usb_printer_control_responder_top.sv =====
// top level of the printer control endpoint responder
// depends on ucr_pkg, ucr_if, ucr_cfg_store and ucr_reply_seq
//
//   channel   direction  transaction
//   in_chan   sink       one setup packet (type, code, value, index, length)
//   out_chan  source     one reply byte, acknowledge or stall, last flag
//   cfg_*     write      one register write, index 0..4, no read-back
//
// a setup packet is decoded as it is taken, then every reply byte passes
// a store read state and then an output load state; the device id has 43 bytes
// the store read ahead of every reply byte keeps bytes from loading back to back
// acknowledge and stall replies skip the store read and go to the output load
// reset clears the store valid bits at once; no clearing pass
// a stalled output holds the sequencer; the next packet is taken once the
// last result sits in the output register
`default_nettype none
module usb_printer_control_responder_top import ucr_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  ucr_req_if.sink                     in_chan,
  ucr_rsp_if.source                   out_chan,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_req_t               store_req;
  logic [CFG_DATA_W-1:0]  store_rdata;

  // configuration and flag store
  ucr_cfg_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (store_req),
    .rd_data   (store_rdata)
  );

  // decode and reply sequencing
  ucr_reply_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .store_req   (store_req),
    .store_rdata (store_rdata)
  );

endmodule
`default_nettype wire
